/* rtl/core/vbc_pkg.sv */
// Shared types, codes and constants of the variometer beep controller.
`default_nettype none

package vbc_pkg;

    // Field widths fixed by the interface
    localparam int OPCODE_W  = 2;
    localparam int VARIO_W   = 14;
    localparam int THRESH_W  = 11;
    localparam int VOLUME_W  = 2;
    localparam int FREQ_W    = 11;
    localparam int DUTY_W    = 8;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 9;
    localparam int BEEP_W    = 9;
    localparam int SILENCE_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    // Opcodes of an input beat
    localparam logic [OPCODE_W-1:0] OP_SAMPLE   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SHUTDOWN = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_ON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_OFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SINK_ON  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SINK_OFF = 3'd4;

    // Configuration reset values
    localparam logic [VOLUME_W-1:0]        VOLUME_RESET   = 2'd1;
    localparam logic signed [THRESH_W-1:0] LIFT_ON_RESET  = 11'sd40;
    localparam logic signed [THRESH_W-1:0] LIFT_OFF_RESET = 11'sd10;
    localparam logic signed [THRESH_W-1:0] SINK_ON_RESET  = -11'sd120;
    localparam logic signed [THRESH_W-1:0] SINK_OFF_RESET = -11'sd100;

    // Tone shaping constants
    localparam logic [FREQ_W-1:0]    LIFT_FREQ_BASE  = 11'd600;
    localparam logic [FREQ_W-1:0]    SINK_FREQ_BASE  = 11'd400;
    localparam logic [BEEP_W-1:0]    BEEP_MS_SLOW    = 9'd350;
    localparam logic [SILENCE_W-1:0] SILENCE_MS_SLOW = 8'd230;
    localparam int LIFT_FREQ_SPAN = 1500 - 600;
    localparam int SINK_FREQ_SPAN = 400 - 150;
    localparam int BEEP_SPAN      = 350 - 100;
    localparam int SILENCE_SPAN   = 230 - 60;

    // Output codes of the mode field
    localparam logic [MODE_W-1:0] MODE_CODE_LIFT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_SINK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_IDLE = 2'd2;

    typedef enum logic [2:0] {
        MODE_LIFT = 3'b001,
        MODE_SINK = 3'b010,
        MODE_IDLE = 3'b100
    } mode_t;

    typedef struct packed {
        logic [VOLUME_W-1:0]        volume_level;
        logic signed [THRESH_W-1:0] lift_on_cms;
        logic signed [THRESH_W-1:0] lift_off_cms;
        logic signed [THRESH_W-1:0] sink_on_cms;
        logic signed [THRESH_W-1:0] sink_off_cms;
    } cfg_t;

    // One beat after the scaling stage, with its precomputed timings
    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic signed [VARIO_W-1:0] vario;
        logic [FREQ_W-1:0]         freq;
        logic [BEEP_W-1:0]         beep_ms;
        logic [SILENCE_W-1:0]      silence_ms;
    } item_t;

    function automatic logic [DUTY_W-1:0] duty_for_level(input logic [VOLUME_W-1:0] level);
        logic [DUTY_W-1:0] duty;
        case (level)
            2'd0:    duty = 8'd0;
            2'd1:    duty = 8'd5;
            2'd2:    duty = 8'd12;
            default: duty = 8'd127;
        endcase
        return duty;
    endfunction

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] code;
        unique case (m)
            MODE_LIFT: code = MODE_CODE_LIFT;
            MODE_SINK: code = MODE_CODE_SINK;
            default:   code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/vbc_scale.sv */
// Scales a clamped magnitude by SPAN / MAX_RATE with a reciprocal multiply.
`default_nettype none

module vbc_scale #(
    parameter int MAX_RATE = 600,
    parameter int SPAN     = 900,
    parameter int MAG_W    = 10,
    parameter int OUT_W    = 10,
    parameter bit ROUND_UP = 1'b0
) (
    input  wire logic [MAG_W-1:0] mag,
    output logic [OUT_W-1:0]      scaled
);

    // With mag and the reciprocal error both below 2^MAG_W, this shift keeps
    // the floor exact and lets the fraction bits tell an exact quotient apart.
    localparam int SHIFT = 2 * MAG_W;
    localparam longint unsigned RECIP =
        ((longint'(SPAN) << SHIFT) + longint'(MAX_RATE) - 1) / longint'(MAX_RATE);
    localparam longint unsigned THRESH =
        ((longint'(1) << SHIFT) + longint'(MAX_RATE) - 1) / longint'(MAX_RATE);
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = MAG_W + RECIP_W;

    logic [PROD_W-1:0]       prod;
    logic [PROD_W-SHIFT-1:0] quot;
    logic [SHIFT-1:0]        frac;
    logic                    round_bit;

    assign prod      = PROD_W'(mag) * PROD_W'(RECIP);
    assign quot      = prod[PROD_W-1:SHIFT];
    assign frac      = prod[SHIFT-1:0];
    assign round_bit = ROUND_UP && (frac >= SHIFT'(THRESH));
    assign scaled    = OUT_W'(quot) + OUT_W'(round_bit);

endmodule

`default_nettype wire

/* rtl/core/vbc_cfg_regs.sv */
// Configuration register bank with a plain write port.
`default_nettype none

module vbc_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [vbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output vbc_pkg::cfg_t                       cfg
);

    import vbc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volume_level <= VOLUME_RESET;
            cfg_reg.lift_on_cms  <= LIFT_ON_RESET;
            cfg_reg.lift_off_cms <= LIFT_OFF_RESET;
            cfg_reg.sink_on_cms  <= SINK_ON_RESET;
            cfg_reg.sink_off_cms <= SINK_OFF_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_VOLUME:   cfg_reg.volume_level <= cfg_wdata[VOLUME_W-1:0];
                REG_LIFT_ON:  cfg_reg.lift_on_cms  <= $signed(cfg_wdata[THRESH_W-1:0]);
                REG_LIFT_OFF: cfg_reg.lift_off_cms <= $signed(cfg_wdata[THRESH_W-1:0]);
                REG_SINK_ON:  cfg_reg.sink_on_cms  <= $signed(cfg_wdata[THRESH_W-1:0]);
                REG_SINK_OFF: cfg_reg.sink_off_cms <= $signed(cfg_wdata[THRESH_W-1:0]);
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/vbc_control.sv */
// Mode machine, beep countdown and result register.
`default_nettype none

module vbc_control (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire vbc_pkg::cfg_t              cfg,
    input  wire logic                       item_valid,
    output logic                            item_ready,
    input  wire vbc_pkg::item_t             item,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            tone_on,
    output logic [vbc_pkg::FREQ_W-1:0]      tone_freq_hz,
    output logic [vbc_pkg::DUTY_W-1:0]      tone_duty,
    output logic [vbc_pkg::MODE_W-1:0]      mode
);

    import vbc_pkg::*;

    mode_t                mode_reg, mode_next;
    logic                 tone_reg, tone_next;
    logic                 run_reg, run_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [FREQ_W-1:0]    freq_reg, freq_next;
    logic [BEEP_W-1:0]    beep_reg, beep_next;
    logic [SILENCE_W-1:0] silence_reg, silence_next;
    logic [FREQ_W-1:0]    lfreq_reg, lfreq_next;
    logic [DUTY_W-1:0]    lduty_reg, lduty_next;

    logic                 out_valid_reg;
    logic                 out_tone_reg;
    logic [FREQ_W-1:0]    out_freq_reg;
    logic [DUTY_W-1:0]    out_duty_reg;
    logic [MODE_W-1:0]    out_mode_reg;

    logic                 accept;
    logic [COUNT_W-1:0]   count_dec;
    logic signed [VARIO_W-1:0] lift_on_x, lift_off_x, sink_on_x, sink_off_x;
    logic                 above_lift_on, below_sink_on;

    assign item_ready = !out_valid_reg || out_ready;
    assign accept     = item_valid && item_ready;

    assign lift_on_x  = {{(VARIO_W-THRESH_W){cfg.lift_on_cms[THRESH_W-1]}},  cfg.lift_on_cms};
    assign lift_off_x = {{(VARIO_W-THRESH_W){cfg.lift_off_cms[THRESH_W-1]}}, cfg.lift_off_cms};
    assign sink_on_x  = {{(VARIO_W-THRESH_W){cfg.sink_on_cms[THRESH_W-1]}},  cfg.sink_on_cms};
    assign sink_off_x = {{(VARIO_W-THRESH_W){cfg.sink_off_cms[THRESH_W-1]}}, cfg.sink_off_cms};

    assign above_lift_on = item.vario > lift_on_x;
    assign below_sink_on = item.vario < sink_on_x;

    assign count_dec = (count_reg != '0) ? count_reg - COUNT_W'(1) : '0;

    always_comb
    begin
        mode_next    = mode_reg;
        tone_next    = tone_reg;
        run_next     = run_reg;
        count_next   = count_reg;
        freq_next    = freq_reg;
        beep_next    = beep_reg;
        silence_next = silence_reg;
        lfreq_next   = lfreq_reg;
        lduty_next   = lduty_reg;
        if (accept)
        begin
            case (item.opcode)
                OP_SAMPLE:
                begin
                    freq_next    = item.freq;
                    beep_next    = item.beep_ms;
                    silence_next = item.silence_ms;
                    unique case (mode_reg)
                        MODE_LIFT:
                        begin
                            if (item.vario < lift_off_x)
                                mode_next = MODE_IDLE;
                        end
                        MODE_SINK:
                        begin
                            if (item.vario > sink_off_x)
                                mode_next = MODE_IDLE;
                        end
                        default:
                        begin
                            // The sink test comes first and wins over lift.
                            if (below_sink_on)
                                mode_next = MODE_SINK;
                            else if (above_lift_on)
                                mode_next = MODE_LIFT;
                            if ((above_lift_on || below_sink_on) && !run_reg)
                            begin
                                run_next   = 1'b1;
                                count_next = COUNT_W'(item.beep_ms);
                                tone_next  = 1'b1;
                                lfreq_next = item.freq;
                                lduty_next = duty_for_level(cfg.volume_level);
                            end
                        end
                    endcase
                end
                OP_TICK:
                begin
                    if (run_reg)
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            if (mode_reg == MODE_IDLE)
                            begin
                                tone_next = 1'b0;
                                run_next  = 1'b0;
                            end
                            else if (tone_reg)
                            begin
                                if (silence_reg == '0)
                                    count_next = COUNT_W'(beep_reg);
                                else
                                begin
                                    tone_next  = 1'b0;
                                    count_next = COUNT_W'(silence_reg);
                                end
                            end
                            else
                            begin
                                tone_next  = 1'b1;
                                count_next = COUNT_W'(beep_reg);
                                lfreq_next = freq_reg;
                                lduty_next = duty_for_level(cfg.volume_level);
                            end
                        end
                    end
                end
                OP_SHUTDOWN:
                begin
                    run_next   = 1'b0;
                    count_next = '0;
                    tone_next  = 1'b0;
                    mode_next  = MODE_IDLE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            tone_reg      <= 1'b0;
            run_reg       <= 1'b0;
            count_reg     <= '0;
            freq_reg      <= '0;
            beep_reg      <= '0;
            silence_reg   <= '0;
            lfreq_reg     <= '0;
            lduty_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            tone_reg    <= tone_next;
            run_reg     <= run_next;
            count_reg   <= count_next;
            freq_reg    <= freq_next;
            beep_reg    <= beep_next;
            silence_reg <= silence_next;
            lfreq_reg   <= lfreq_next;
            lduty_reg   <= lduty_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_tone_reg <= tone_next;
            out_freq_reg <= tone_next ? lfreq_next : '0;
            out_duty_reg <= tone_next ? lduty_next : '0;
            out_mode_reg <= mode_code(mode_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign tone_on      = out_tone_reg;
    assign tone_freq_hz = out_freq_reg;
    assign tone_duty    = out_duty_reg;
    assign mode         = out_mode_reg;

endmodule

`default_nettype wire

/* rtl/core/vario_beep_controller.sv */
// Top level of the variometer beep controller: input and scaling stages.
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | opcode, vario_cms
// out      | out_valid/ out_ready | tone_on, tone_freq_hz, tone_duty, mode
// cfg      | cfg_wr_en            | cfg_index, cfg_wdata (no wait, no read-back)
//
// Every input beat gives exactly one result beat. The block takes one beat per
// cycle while the output does not stall; a result passes through the input
// register, the scaling register and the result register in series.
// Reset clears every stage to empty and loads the register defaults; mode
// starts idle with the tone off. A stall on the output holds the result
// register, and the stall then backs up through the two earlier stages.
//
// The first stage clamps the vertical speed and runs three reciprocal
// multiplies that give the sample's frequency, beep length and silence
// length. These depend on the sample alone, so they are worked out before the
// beat reaches the mode machine, which then needs only compares and a
// decrement to update its state within the cycle.

module vario_beep_controller #(
    parameter int MAX_RATE_CMS = 600
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [vbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [vbc_pkg::OPCODE_W-1:0]   opcode,
    input  wire logic signed [vbc_pkg::VARIO_W-1:0] vario_cms,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                tone_on,
    output logic [vbc_pkg::FREQ_W-1:0]          tone_freq_hz,
    output logic [vbc_pkg::DUTY_W-1:0]          tone_duty,
    output logic [vbc_pkg::MODE_W-1:0]          mode
);

    import vbc_pkg::*;

    localparam int MAG_W       = $clog2(MAX_RATE_CMS + 1);
    localparam int LIFT_Q_W    = $clog2(LIFT_FREQ_SPAN + 1);
    localparam int SINK_Q_W    = $clog2(SINK_FREQ_SPAN + 1);
    localparam int SILENCE_Q_W = $clog2(SILENCE_SPAN + 1);

    cfg_t cfg;

    // Input register
    logic                      s1_valid_reg;
    logic [OPCODE_W-1:0]       s1_opcode_reg;
    logic signed [VARIO_W-1:0] s1_vario_reg;

    // Scaling register
    logic  s2_valid_reg;
    item_t s2_item_reg;
    item_t s2_item_next;

    logic ctrl_ready;
    logic s2_advance, s2_free, s1_advance;

    logic [VARIO_W-1:0]     abs_vario;
    logic [MAG_W-1:0]       mag;
    logic                   positive;
    logic [LIFT_Q_W-1:0]    lift_q;
    logic [SINK_Q_W-1:0]    sink_q;
    logic [SILENCE_Q_W-1:0] silence_q;

    vbc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Handshake through the stages: each stage moves on when the next is free.
    assign s2_advance = s2_valid_reg && ctrl_ready;
    assign s2_free    = !s2_valid_reg || s2_advance;
    assign s1_advance = s1_valid_reg && s2_free;
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;
            if (s1_advance)
                s2_valid_reg <= 1'b1;
            else if (s2_advance)
                s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_opcode_reg <= opcode;
            s1_vario_reg  <= vario_cms;
        end
        if (s1_advance)
            s2_item_reg <= s2_item_next;
    end

    // Magnitude of the sample, clamped to the full-scale rate.
    assign abs_vario = s1_vario_reg[VARIO_W-1] ? (~s1_vario_reg + VARIO_W'(1))
                                                : s1_vario_reg;
    assign mag       = (abs_vario > VARIO_W'(MAX_RATE_CMS)) ? MAG_W'(MAX_RATE_CMS)
                                                            : MAG_W'(abs_vario);
    assign positive  = !s1_vario_reg[VARIO_W-1] && (s1_vario_reg != '0);

    // Lift pitch rounds down; sink pitch, beep and silence round the step up.
    vbc_scale #(
        .MAX_RATE (MAX_RATE_CMS),
        .SPAN     (LIFT_FREQ_SPAN),
        .MAG_W    (MAG_W),
        .OUT_W    (LIFT_Q_W),
        .ROUND_UP (1'b0)
    ) u_scale_lift (
        .mag    (mag),
        .scaled (lift_q)
    );

    // Sink pitch and beep length share the same span, so one unit serves both.
    vbc_scale #(
        .MAX_RATE (MAX_RATE_CMS),
        .SPAN     (SINK_FREQ_SPAN),
        .MAG_W    (MAG_W),
        .OUT_W    (SINK_Q_W),
        .ROUND_UP (1'b1)
    ) u_scale_sink (
        .mag    (mag),
        .scaled (sink_q)
    );

    vbc_scale #(
        .MAX_RATE (MAX_RATE_CMS),
        .SPAN     (SILENCE_SPAN),
        .MAG_W    (MAG_W),
        .OUT_W    (SILENCE_Q_W),
        .ROUND_UP (1'b1)
    ) u_scale_silence (
        .mag    (mag),
        .scaled (silence_q)
    );

    always_comb
    begin
        s2_item_next.opcode     = s1_opcode_reg;
        s2_item_next.vario      = s1_vario_reg;
        s2_item_next.freq       = positive ? LIFT_FREQ_BASE + FREQ_W'(lift_q)
                                           : SINK_FREQ_BASE - FREQ_W'(sink_q);
        s2_item_next.beep_ms    = BEEP_MS_SLOW - BEEP_W'(sink_q);
        s2_item_next.silence_ms = positive ? SILENCE_MS_SLOW - SILENCE_W'(silence_q)
                                           : '0;
    end

    vbc_control u_control (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (s2_valid_reg),
        .item_ready   (ctrl_ready),
        .item         (s2_item_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tone_on      (tone_on),
        .tone_freq_hz (tone_freq_hz),
        .tone_duty    (tone_duty),
        .mode         (mode)
    );

endmodule

`default_nettype wire

/* bench/vario_beep_controller_test.sv */
// Self-checking testbench of the variometer beep controller with its own tone predictor.
module vario_beep_controller_test;

    import vbc_pkg::*;

    // The block is built with the default rate limit, and the predictor scales by the same value.
    localparam int RATE_CMS        = 600;
    localparam int IDLE_PCT        = 21;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int PHASE_ITEMS     = 200;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TIMEOUT_UNITS   = 2_000_000;

    // The opcode field has one code that the block does not use; it must report status only.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int DUTY_STEPS [4]   = '{0, 5, 12, 127};
    localparam int VARIO_EDGES [10] =
        '{-8192, 8191, -5000, 5000, 600, -600, 601, -601, 0, 1};

    // One result beat as the block should present it.
    typedef struct packed {
        logic              tone;
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
        logic [MODE_W-1:0] mode;
    } tone_status_t;

    // Tracks the controller's mode machine and countdown, and keeps the status beats that are
    // still to come out of the block, oldest first.
    class beep_scoreboard;
        tone_status_t        status_queue[$];
        int                  fails;
        logic [VOLUME_W-1:0] volume;
        int                  lift_on, lift_off, sink_on, sink_off;
        logic [MODE_W-1:0]   ctl_mode;
        bit                  tone_live, counting;
        int                  count_ms, vario_last, freq_now, freq_held, duty_held;

        function new();
            fails      = 0;
            volume     = VOLUME_RESET;
            lift_on    = LIFT_ON_RESET;
            lift_off   = LIFT_OFF_RESET;
            sink_on    = SINK_ON_RESET;
            sink_off   = SINK_OFF_RESET;
            ctl_mode   = MODE_CODE_IDLE;
            tone_live  = 1'b0;
            counting   = 1'b0;
            count_ms   = 0;
            vario_last = 0;
            freq_now   = 0;
            freq_held  = 0;
            duty_held  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_VOLUME:   volume   = data[VOLUME_W-1:0];
                REG_LIFT_ON:  lift_on  = $signed(data);
                REG_LIFT_OFF: lift_off = $signed(data);
                REG_SINK_ON:  sink_on  = $signed(data);
                REG_SINK_OFF: sink_off = $signed(data);
                default: ;
            endcase
        endfunction

        function int rate_mag(int v);
            int a;
            a = (v < 0) ? -v : v;
            return (a > RATE_CMS) ? RATE_CMS : a;
        endfunction

        // Scaled magnitude, rounded up, so that subtracting it truncates towards zero.
        function int ceil_span(int v, int span);
            return (rate_mag(v) * span + RATE_CMS - 1) / RATE_CMS;
        endfunction

        function int freq_for(int v);
            if (v > 0)
                return int'(LIFT_FREQ_BASE) + rate_mag(v) * LIFT_FREQ_SPAN / RATE_CMS;
            return int'(SINK_FREQ_BASE) - ceil_span(v, SINK_FREQ_SPAN);
        endfunction

        function int beep_ms_for(int v);
            return int'(BEEP_MS_SLOW) - ceil_span(v, BEEP_SPAN);
        endfunction

        function int silence_ms_for(int v);
            if (v <= 0)
                return 0;
            return int'(SILENCE_MS_SLOW) - ceil_span(v, SILENCE_SPAN);
        endfunction

        function void tone_start();
            freq_held = freq_now;
            duty_held = DUTY_STEPS[volume];
            tone_live = 1'b1;
        endfunction

        function void arm(int ms);
            count_ms = ms & 'h1FF;
            counting = 1'b1;
        endfunction

        // Countdown has reached zero: end of a beep or of a silence.
        function void countdown_done();
            int gap_ms;
            if (ctl_mode == MODE_CODE_IDLE) begin
                tone_live = 1'b0;
                counting  = 1'b0;
                return;
            end
            gap_ms = silence_ms_for(vario_last);
            if (!tone_live) begin
                tone_start();
                arm(beep_ms_for(vario_last));
            end else if (gap_ms == 0) begin
                // Sinking: the tone carries straight on, without a fresh latch.
                arm(beep_ms_for(vario_last));
            end else begin
                tone_live = 1'b0;
                arm(gap_ms);
            end
        endfunction

        function void take_sample(int v);
            vario_last = v;
            freq_now   = freq_for(v);
            case (ctl_mode)
                MODE_CODE_LIFT: if (v < lift_off) ctl_mode = MODE_CODE_IDLE;
                MODE_CODE_SINK: if (v > sink_off) ctl_mode = MODE_CODE_IDLE;
                default:
                begin
                    // The sink test comes second, so it wins when both thresholds are crossed.
                    if (v > lift_on)
                        ctl_mode = MODE_CODE_LIFT;
                    if (v < sink_on)
                        ctl_mode = MODE_CODE_SINK;
                    if (ctl_mode != MODE_CODE_IDLE && !counting) begin
                        arm(beep_ms_for(v));
                        tone_start();
                    end
                end
            endcase
        endfunction

        function void note_beat(logic [OPCODE_W-1:0] op, logic signed [VARIO_W-1:0] v);
            tone_status_t s;
            int           vi;
            vi = v;
            case (op)
                OP_SAMPLE: take_sample(vi);
                OP_TICK:
                begin
                    if (counting) begin
                        if (count_ms > 0)
                            count_ms--;
                        if (count_ms == 0)
                            countdown_done();
                    end
                end
                OP_SHUTDOWN:
                begin
                    counting  = 1'b0;
                    count_ms  = 0;
                    tone_live = 1'b0;
                    ctl_mode  = MODE_CODE_IDLE;
                end
                default: ;
            endcase
            s.tone = tone_live;
            s.freq = tone_live ? freq_held[FREQ_W-1:0] : '0;
            s.duty = tone_live ? duty_held[DUTY_W-1:0] : '0;
            s.mode = ctl_mode;
            status_queue.push_back(s);
        endfunction

        function void check_beat(tone_status_t got);
            tone_status_t want;
            if (status_queue.size() == 0) begin
                $error("result beat arrived with no expectation waiting");
                fails++;
                return;
            end
            want = status_queue.pop_front();
            if (got.tone !== want.tone) begin
                $error("tone_on: expected %0d, actual %0d", want.tone, got.tone);
                fails++;
            end
            if (got.freq !== want.freq) begin
                $error("tone_freq_hz: expected %0d, actual %0d", want.freq, got.freq);
                fails++;
            end
            if (got.duty !== want.duty) begin
                $error("tone_duty: expected %0d, actual %0d", want.duty, got.duty);
                fails++;
            end
            if (got.mode !== want.mode) begin
                $error("mode: expected %0d, actual %0d", want.mode, got.mode);
                fails++;
            end
        endfunction

        function int pending();
            return status_queue.size();
        endfunction
    endclass

    // Every input of the block holds a known value from time zero.
    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = REG_VOLUME;
    logic [CFG_DATA_W-1:0]      cfg_wdata    = '0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic [OPCODE_W-1:0]        opcode       = OP_SAMPLE;
    logic signed [VARIO_W-1:0]  vario_cms    = '0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic                       tone_on;
    logic [FREQ_W-1:0]          tone_freq_hz;
    logic [DUTY_W-1:0]          tone_duty;
    logic [MODE_W-1:0]          mode;

    // steady_flow switches off idling on both sides; hold_off_req asks the receiver for one
    // long stall.
    bit             steady_flow  = 1'b0;
    bit             hold_off_req = 1'b0;
    int             beats_sent   = 0;
    beep_scoreboard sb           = new();

    vario_beep_controller #(.MAX_RATE_CMS(RATE_CMS)) uut (.*);

    always #5 clk = ~clk;

    // Hard limit on the run, far beyond the slowest correct run.
    initial begin
        #(TIMEOUT_UNITS);
        $display("TB_ERROR");
        $finish;
    end

    // Result side. Ready drops at random, except during the steady phase; once the stimulus
    // asks for it, ready is held low for a long stretch so that the pipeline fills and the
    // block has to stall its input.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Outputs are sampled at the edge, before any update from that edge lands, so the beat
    // seen here is the one that the handshake moves.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat({tone_on, tone_freq_hz, tone_duty, mode});
    end

    // Offers one input beat, possibly after some idle cycles, and waits until it is taken.
    // The expectation is noted at the edge that accepts the beat.
    task automatic send_beat(input logic [OPCODE_W-1:0] op,
                             input logic signed [VARIO_W-1:0] v);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        vario_cms <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_beat(op, v);
        beats_sent++;
    endtask

    // Ticks carry a vario field that the block must ignore, so it is filled with noise.
    task automatic tick_run(input int n);
        repeat (n) send_beat(OP_TICK, VARIO_W'($urandom));
    endtask

    // Vertical speed for a sample: mostly around the interesting span, with the field
    // extremes, the rate limit edges and the current thresholds (plus and minus one) mixed in.
    function automatic logic signed [VARIO_W-1:0] pick_vario();
        int r;
        int pick;
        r = $urandom_range(99);
        if (r < 12) begin
            pick = $urandom;
        end else if (r < 24) begin
            pick = VARIO_EDGES[$urandom_range(9)];
        end else if (r < 44) begin
            case ($urandom_range(3))
                0:       pick = sb.lift_on;
                1:       pick = sb.lift_off;
                2:       pick = sb.sink_on;
                default: pick = sb.sink_off;
            endcase
            pick = pick + int'($urandom_range(2)) - 1;
        end else begin
            pick = int'($urandom_range(2400)) - 1200;
        end
        return pick[VARIO_W-1:0];
    endfunction

    // Walks the block through entry, hold and exit of each mode under the reset thresholds,
    // the field extremes, shutdown and the unused opcode.
    task automatic directed_beats();
        send_beat(OP_TICK, 0);             // tick with no countdown running does nothing
        send_beat(OP_UNUSED, 8191);        // unused code only reports status
        send_beat(OP_SAMPLE, 0);
        send_beat(OP_SAMPLE, 41);          // idle to lift, tone starts and latches
        send_beat(OP_SAMPLE, 8191);        // clamps; latched frequency must not move
        send_beat(OP_TICK, -8192);
        send_beat(OP_SAMPLE, 14'sh1555);
        send_beat(OP_SAMPLE, -8192);       // lift straight back to idle
        send_beat(OP_SAMPLE, -8192);       // idle to sink, countdown still running
        send_beat(OP_TICK, 14'sh2AAA);
        send_beat(OP_SHUTDOWN, 0);
        send_beat(OP_SAMPLE, -121);        // sink entry restarts the tone
        send_beat(OP_SAMPLE, -100);        // on the off threshold: stays in sink
        send_beat(OP_SAMPLE, -99);         // leaves sink
        send_beat(OP_SAMPLE, 600);
        send_beat(OP_SAMPLE, 5000);
        send_beat(OP_SAMPLE, -5000);
        send_beat(OP_SAMPLE, 1);
        send_beat(OP_SAMPLE, -1);
        send_beat(OP_UNUSED, -8192);
        send_beat(OP_SHUTDOWN, 8191);
        send_beat(OP_TICK, 0);
    endtask

    // Mostly a sample followed by a run of ticks, now and then long enough to see several
    // beeps and silences; the rest is stray shutdowns, unused codes and lone ticks.
    task automatic random_beats(input int budget);
        int stop_at;
        int kind;
        stop_at = beats_sent + budget;
        while (beats_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                send_beat(OP_SAMPLE, pick_vario());
                if ($urandom_range(5) == 0)
                    tick_run($urandom_range(360, 100));
                else
                    tick_run($urandom_range(20));
            end else if (kind < 83) begin
                send_beat(OP_SHUTDOWN, VARIO_W'($urandom));
            end else if (kind < 91) begin
                send_beat(OP_UNUSED, VARIO_W'($urandom));
            end else begin
                send_beat(OP_TICK, VARIO_W'($urandom));
            end
        end
    endtask

    // Every input beat gives a result, so an empty queue means the pipeline is empty; a settle
    // wait follows before any register write.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all five registers on consecutive cycles, keeping the enable high throughout.
    task automatic write_regs(input int vol, input int lon, input int loff,
                              input int son, input int soff);
        int                   vals [5];
        logic [CFG_IDX_W-1:0] regs [5];
        vals = '{vol, lon, loff, son, soff};
        regs = '{REG_VOLUME, REG_LIFT_ON, REG_LIFT_OFF, REG_SINK_ON, REG_SINK_OFF};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i][CFG_DATA_W-1:0];
            sb.set_reg(regs[i], vals[i][CFG_DATA_W-1:0]);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values first.
        directed_beats();
        random_beats(PHASE_ITEMS);
        drain();

        // Volume off and thresholds at their extremes, so the modes are hard to enter and
        // harder to leave. The long receiver stall happens here.
        write_regs(0, 1023, -1024, -1024, 1023);
        hold_off_req = 1'b1;
        random_beats(PHASE_ITEMS);
        drain();

        // Crossed thresholds: from idle both tests pass on most samples and sink must win.
        write_regs(3, -1024, -1024, 1023, 1023);
        random_beats(PHASE_ITEMS);
        drain();

        // All thresholds at zero, with no idling on either side.
        steady_flow = 1'b1;
        write_regs(2, 0, 0, 0, 0);
        random_beats(PHASE_ITEMS);
        drain();
        steady_flow = 1'b0;

        write_regs($urandom_range(3), int'($urandom_range(600)) - 300,
                   int'($urandom_range(600)) - 300, int'($urandom_range(600)) - 300,
                   int'($urandom_range(600)) - 300);
        random_beats(PHASE_ITEMS);
        drain();

        if (sb.fails == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/vbc_pkg.sv
rtl/core/vbc_scale.sv
rtl/core/vbc_cfg_regs.sv
rtl/core/vbc_control.sv
rtl/core/vario_beep_controller.sv
bench/vario_beep_controller_test.sv
